@@ hw/rtl/i2cee_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM slave model package
// Register indexes, reset values, reply kinds and sizes shared by the block.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    localparam int MEM_BYTES_DEF = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLAVE_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_USE   = 2'd2;

    localparam logic [7:0]  SLAVE_BASE_RST = 8'd160;
    localparam logic [7:0]  SLAVE_MASK_RST = 8'd0;
    localparam logic [12:0] SIZE_USE_RST   = 13'd4096;

    localparam logic REPLY_ACK  = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    localparam logic [7:0]  ACK_DATA   = 8'd1;
    localparam logic [7:0]  ERASED     = 8'hFF;
    localparam logic [16:0] SHORT_SIZE = 17'd256;

endpackage

@@ hw/rtl/i2c_eeprom_slave_model.sv @@
// ----------------------------------------------------------------------------
// I2C EEPROM slave model
// Transaction-level 24Cxx-style slave: decodes stop/start/write/read events,
// keeps the word address and serves data from a synchronous byte memory.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser                      | tlast
//  s_      | in  | [7:0] address_byte, [15:8] data | [0] stop [1] start [2] write [3] read | -
//  m_      | out | [7:0] reply_address, [15:8] reply_data | [0] reply_kind   | last_reply
//  cfg_    | in  | index 0 base, 1 mask, 2 size in use; cfg_wdata 13 bits           | -
//
//  An item is taken in idle, then answered with a start ack, a write ack and a
//  read (memory read port access, then the data reply) as its flags ask; the
//  memory port and the single reply register set the pace, with s_tready low.
//  After reset a clearing pass writes 0xFF over MEM_BYTES entries, one per
//  cycle, with s_tready low; configuration writes are taken during it.
//  A stalled m_ side holds the sequencer at the next reply.
// ----------------------------------------------------------------------------
module i2c_eeprom_slave_model #(
    parameter int MEM_BYTES = i2cee_pkg::MEM_BYTES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // address_byte, data_byte
    input  logic [3:0]                       s_tuser,   // stop, start, write, read

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [15:0]                      m_tdata,   // reply_address, reply_data
    output logic                             m_tuser,   // reply_kind
    output logic                             m_tlast,

    input  logic                             cfg_wr_en,
    input  logic [i2cee_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [i2cee_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int          AW       = $clog2(MEM_BYTES);
    localparam logic [16:0] MEM_SIZE = 17'(MEM_BYTES);

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_WRITE, ST_RADDR, ST_RDATA
    } state_t;

    logic [7:0] mem [MEM_BYTES];

    state_t        state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [7:0]    base_reg, base_next;
    logic [7:0]    mask_reg, mask_next;
    logic [12:0]   size_reg, size_next;
    logic          sel_valid_reg, sel_valid_next;
    logic [7:0]    sel_addr_reg, sel_addr_next;
    logic [1:0]    byte_cnt_reg, byte_cnt_next;
    logic [15:0]   word_reg, word_next;
    logic          wr_reg, wr_next;
    logic          rd_reg, rd_next;
    logic [7:0]    dbyte_reg, dbyte_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [15:0]   m_tdata_reg, m_tdata_next;
    logic          m_tuser_reg, m_tuser_next;
    logic          m_tlast_reg, m_tlast_next;
    logic [7:0]    rdata_reg;

    logic [16:0]   eff_size;
    logic [15:0]   amask;
    logic          addr_two;
    logic          out_free;
    logic          accept;
    logic          match;
    logic          in_stop, in_start, in_wr, in_rd;
    logic [8:0]    blk;
    logic [15:0]   word_or;
    logic [15:0]   word_idx;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic          mem_re;

    assign in_stop  = s_tuser[0];
    assign in_start = s_tuser[1];
    assign in_wr    = s_tuser[2];
    assign in_rd    = s_tuser[3];

    always_comb begin
        eff_size = {4'd0, size_reg};
        if (eff_size == 17'd0) begin
            eff_size = 17'd1;
        end
        if (eff_size > MEM_SIZE) begin
            eff_size = MEM_SIZE;
        end
    end

    assign amask    = 16'(eff_size - 17'd1);
    assign addr_two = (eff_size > i2cee_pkg::SHORT_SIZE);
    assign word_idx = word_reg & amask;
    assign blk      = {1'b0, sel_addr_reg & 8'hFE} - {1'b0, base_reg};
    assign word_or  = word_reg | (byte_cnt_reg[0] ? {dbyte_reg, 8'h00} : {8'h00, dbyte_reg});
    assign match    = ((base_reg & ~mask_reg) == (s_tdata[7:0] & ~mask_reg));
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        base_next      = base_reg;
        mask_next      = mask_reg;
        size_next      = size_reg;
        sel_valid_next = sel_valid_reg;
        sel_addr_next  = sel_addr_reg;
        byte_cnt_next  = byte_cnt_reg;
        word_next      = word_reg;
        wr_next        = wr_reg;
        rd_next        = rd_reg;
        dbyte_next     = dbyte_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        m_tlast_next   = m_tlast_reg;
        mem_we         = 1'b0;
        mem_waddr      = word_idx[AW-1:0];
        mem_wdata      = dbyte_reg;
        mem_re         = 1'b0;

        if (cfg_wr_en) begin
            unique case (cfg_addr)
                i2cee_pkg::REG_SLAVE_BASE: base_next = cfg_wdata[7:0];
                i2cee_pkg::REG_SLAVE_MASK: mask_next = cfg_wdata[7:0];
                i2cee_pkg::REG_SIZE_USE:   size_next = cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = i2cee_pkg::ERASED;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(MEM_BYTES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    wr_next    = in_wr;
                    rd_next    = in_rd;
                    dbyte_next = s_tdata[15:8];
                    if (in_stop) begin
                        sel_valid_next = 1'b0;
                        sel_addr_next  = 8'd0;
                        byte_cnt_next  = 2'd0;
                        word_next      = 16'd0;
                    end
                    if (in_start) begin
                        sel_valid_next = match;
                        sel_addr_next  = match ? s_tdata[7:0] : 8'd0;
                        byte_cnt_next  = 2'd0;
                    end
                    if (in_start && match) begin
                        state_next = ST_START;
                    end else if (sel_valid_next && in_wr) begin
                        state_next = ST_WRITE;
                    end else if (sel_valid_next && in_rd) begin
                        state_next = ST_RADDR;
                    end
                end
            end
            ST_START: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {i2cee_pkg::ACK_DATA, sel_addr_reg};
                    m_tuser_next  = i2cee_pkg::REPLY_ACK;
                    m_tlast_next  = !wr_reg && !rd_reg;
                    state_next    = wr_reg ? ST_WRITE : (rd_reg ? ST_RADDR : ST_IDLE);
                end
            end
            ST_WRITE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {i2cee_pkg::ACK_DATA, sel_addr_reg};
                    m_tuser_next  = i2cee_pkg::REPLY_ACK;
                    m_tlast_next  = !rd_reg;
                    if (addr_two ? (byte_cnt_reg < 2'd2) : (byte_cnt_reg == 2'd0)) begin
                        if (addr_two ? (byte_cnt_reg == 2'd1) : (byte_cnt_reg == 2'd0)) begin
                            word_next = (word_or + {blk, 7'd0}) & amask;
                        end else begin
                            word_next = word_or & amask;
                        end
                    end else begin
                        mem_we    = 1'b1;
                        word_next = (word_reg + 16'd1) & amask;
                    end
                    if (byte_cnt_reg != 2'd3) begin
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                    end
                    state_next = rd_reg ? ST_RADDR : ST_IDLE;
                end
            end
            ST_RADDR: begin
                mem_re     = 1'b1;
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {rdata_reg, sel_addr_reg};
                    m_tuser_next  = i2cee_pkg::REPLY_READ;
                    m_tlast_next  = 1'b1;
                    word_next     = (word_reg + 16'd1) & amask;
                    if (byte_cnt_reg != 2'd3) begin
                        byte_cnt_next = byte_cnt_reg + 2'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rdata_reg <= mem[word_idx[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            base_reg      <= i2cee_pkg::SLAVE_BASE_RST;
            mask_reg      <= i2cee_pkg::SLAVE_MASK_RST;
            size_reg      <= i2cee_pkg::SIZE_USE_RST;
            sel_valid_reg <= 1'b0;
            sel_addr_reg  <= 8'd0;
            byte_cnt_reg  <= 2'd0;
            word_reg      <= 16'd0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            base_reg      <= base_next;
            mask_reg      <= mask_next;
            size_reg      <= size_next;
            sel_valid_reg <= sel_valid_next;
            sel_addr_reg  <= sel_addr_next;
            byte_cnt_reg  <= byte_cnt_next;
            word_reg      <= word_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        wr_reg      <= wr_next;
        rd_reg      <= rd_next;
        dbyte_reg   <= dbyte_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_clear_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("input taken during clearing pass");

    a_reply_needs_select: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_START || state_reg == ST_WRITE ||
         state_reg == ST_RADDR || state_reg == ST_RDATA) |-> sel_valid_reg)
        else $error("reply sequenced while not selected");

    a_read_follows_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RADDR) |=> (state_reg == ST_RDATA))
        else $error("read data stage skipped");

    a_read_reply_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RDATA && out_free) |=> (m_tvalid && m_tlast &&
         m_tuser == i2cee_pkg::REPLY_READ))
        else $error("read reply not marked last");

endmodule
